/* rtl/rrts_pkg.sv */
package rrts_pkg;

  localparam int TASK_SLOTS_DEF = 16;

  localparam int MODE_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int PRIO_W  = 8;
  localparam int KIND_W  = 2;
  localparam int PID_W   = 16;
  localparam int ERR_W   = 2;

  localparam logic [PRIO_W-1:0] MAIN_PRIO = 8'd31;
  localparam logic [SLOT_W-1:0] IDLE_RESET = 4'd1;

  // event codes
  localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RESCHED = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLOCK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNBLOCK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_YIELD   = 3'd4;

  // wait kinds of a block event
  localparam logic [KIND_W-1:0] KIND_WAITING = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HANGING = 2'd2;

  typedef enum logic [2:0] {
    ST_RUNNING = 3'd0,
    ST_READY   = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_WAITING = 3'd3,
    ST_HANGING = 3'd4,
    ST_FREE    = 3'd5
  } status_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE          = 2'd0,
    ERR_NOT_WAITING   = 2'd1,
    ERR_BUSY          = 2'd2,
    ERR_NONE_RUNNABLE = 2'd3
  } err_t;

  typedef struct packed {
    status_t             status;
    logic [PRIO_W-1:0]   prio;
    logic [PRIO_W-1:0]   ticks;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  localparam slot_entry_t ENTRY_MAIN = '{status: ST_RUNNING, prio: MAIN_PRIO, ticks: MAIN_PRIO};
  localparam slot_entry_t ENTRY_FREE = '{status: ST_FREE, prio: '0, ticks: '0};

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SLOT_W-1:0]  task_req;
    logic [PRIO_W-1:0]  priority_req;
    logic [KIND_W-1:0]  wait_kind;
  } sched_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  running_task;
    logic [PRIO_W-1:0]  slice_ticks;
    logic               switched;
    logic [PID_W-1:0]   new_pid;
    logic [ERR_W-1:0]   error;
  } sched_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_CREATE,
    S_BLOCK,
    S_UNBLK,
    S_YIELD,
    S_P1_RD,
    S_P1,
    S_P2,
    S_IDLE_CHK,
    S_POP,
    S_RUN,
    S_OUT_RD,
    S_OUT
  } state_t;

  // slot table address select
  typedef enum logic [2:0] {
    TS_CUR,
    TS_REQ,
    TS_IDLE,
    TS_NEXT,
    TS_RING
  } tab_sel_t;

  // slot table write data select
  typedef enum logic [1:0] {
    WS_CREATE,
    WS_STATUS,
    WS_RELOAD
  } wr_sel_t;

  typedef struct packed {
    logic      latch_item;
    logic      tab_rd;
    logic      tab_wr;
    tab_sel_t  tab_sel;
    wr_sel_t   wr_sel;
    status_t   wr_status;
    logic      wr_use_kind;
    logic      push_back;
    logic      push_back_req;
    logic      push_front;
    logic      ring_rd;
    logic      pop;
    logic      set_err;
    err_t      err_code;
    logic      set_switched;
    logic      pid_inc;
    logic      cur_to_idle;
    logic      cur_to_next;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              req_ok;
    logic              idle_ok;
    status_t           rd_status;
    logic              ring_empty;
    logic              out_free;
  } dp_sts_t;

endpackage

/* rtl/rrts_ram.sv */
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rrts_ctrl.sv */
module rrts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              evt_valid,
  output logic              evt_stall,
  input  rrts_pkg::dp_sts_t sts,
  output rrts_pkg::dp_cmd_t cmd
);

  rrts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign evt_stall = (state != rrts_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      rrts_pkg::S_IDLE: begin
        if (evt_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = rrts_pkg::S_PRE;
        end
      end
      rrts_pkg::S_PRE: begin
        unique case (sts.mode)
          rrts_pkg::MODE_CREATE: begin
            if (sts.req_ok) begin
              cmd.tab_rd  = 1'b1;
              cmd.tab_sel = rrts_pkg::TS_REQ;
              state_next  = rrts_pkg::S_CREATE;
            end else begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rrts_pkg::ERR_BUSY;
              state_next   = rrts_pkg::S_OUT_RD;
            end
          end
          rrts_pkg::MODE_RESCHED: begin
            state_next = rrts_pkg::S_P1_RD;
          end
          rrts_pkg::MODE_BLOCK: begin
            cmd.tab_rd  = 1'b1;
            cmd.tab_sel = rrts_pkg::TS_CUR;
            state_next  = rrts_pkg::S_BLOCK;
          end
          rrts_pkg::MODE_UNBLOCK: begin
            if (sts.req_ok) begin
              cmd.tab_rd  = 1'b1;
              cmd.tab_sel = rrts_pkg::TS_REQ;
              state_next  = rrts_pkg::S_UNBLK;
            end else begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rrts_pkg::ERR_NOT_WAITING;
              state_next   = rrts_pkg::S_OUT_RD;
            end
          end
          rrts_pkg::MODE_YIELD: begin
            cmd.tab_rd  = 1'b1;
            cmd.tab_sel = rrts_pkg::TS_CUR;
            state_next  = rrts_pkg::S_YIELD;
          end
          default: begin
            state_next = rrts_pkg::S_OUT_RD;
          end
        endcase
      end
      rrts_pkg::S_CREATE: begin
        if (sts.rd_status == rrts_pkg::ST_FREE) begin
          cmd.pid_inc       = 1'b1;
          cmd.tab_wr        = 1'b1;
          cmd.tab_sel       = rrts_pkg::TS_REQ;
          cmd.wr_sel        = rrts_pkg::WS_CREATE;
          cmd.push_back     = 1'b1;
          cmd.push_back_req = 1'b1;
        end else begin
          cmd.set_err  = 1'b1;
          cmd.err_code = rrts_pkg::ERR_BUSY;
        end
        state_next = rrts_pkg::S_OUT_RD;
      end
      rrts_pkg::S_BLOCK: begin
        cmd.tab_wr       = 1'b1;
        cmd.tab_sel      = rrts_pkg::TS_CUR;
        cmd.wr_sel       = rrts_pkg::WS_STATUS;
        cmd.wr_use_kind  = 1'b1;
        cmd.set_switched = 1'b1;
        state_next       = rrts_pkg::S_P2;
      end
      rrts_pkg::S_UNBLK: begin
        if (sts.rd_status == rrts_pkg::ST_BLOCKED || sts.rd_status == rrts_pkg::ST_WAITING ||
            sts.rd_status == rrts_pkg::ST_HANGING) begin
          cmd.push_front   = 1'b1;
          cmd.tab_wr       = 1'b1;
          cmd.tab_sel      = rrts_pkg::TS_REQ;
          cmd.wr_sel       = rrts_pkg::WS_STATUS;
          cmd.wr_status    = rrts_pkg::ST_READY;
          cmd.set_switched = 1'b1;
          state_next       = rrts_pkg::S_P1_RD;
        end else begin
          cmd.set_err  = 1'b1;
          cmd.err_code = rrts_pkg::ERR_NOT_WAITING;
          state_next   = rrts_pkg::S_OUT_RD;
        end
      end
      rrts_pkg::S_YIELD: begin
        cmd.push_back    = 1'b1;
        cmd.tab_wr       = 1'b1;
        cmd.tab_sel      = rrts_pkg::TS_CUR;
        cmd.wr_sel       = rrts_pkg::WS_STATUS;
        cmd.wr_status    = rrts_pkg::ST_READY;
        cmd.set_switched = 1'b1;
        state_next       = rrts_pkg::S_P2;
      end
      rrts_pkg::S_P1_RD: begin
        cmd.tab_rd       = 1'b1;
        cmd.tab_sel      = rrts_pkg::TS_CUR;
        cmd.set_switched = 1'b1;
        state_next       = rrts_pkg::S_P1;
      end
      rrts_pkg::S_P1: begin
        if (sts.rd_status == rrts_pkg::ST_RUNNING) begin
          cmd.push_back = 1'b1;
          cmd.tab_wr    = 1'b1;
          cmd.tab_sel   = rrts_pkg::TS_CUR;
          cmd.wr_sel    = rrts_pkg::WS_RELOAD;
        end
        state_next = rrts_pkg::S_P2;
      end
      rrts_pkg::S_P2: begin
        if (!sts.ring_empty) begin
          cmd.ring_rd = 1'b1;
          state_next  = rrts_pkg::S_POP;
        end else if (sts.idle_ok) begin
          cmd.tab_rd  = 1'b1;
          cmd.tab_sel = rrts_pkg::TS_IDLE;
          state_next  = rrts_pkg::S_IDLE_CHK;
        end else begin
          cmd.set_err  = 1'b1;
          cmd.err_code = rrts_pkg::ERR_NONE_RUNNABLE;
          state_next   = rrts_pkg::S_OUT_RD;
        end
      end
      rrts_pkg::S_IDLE_CHK: begin
        if (sts.rd_status == rrts_pkg::ST_FREE) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = rrts_pkg::ERR_NONE_RUNNABLE;
        end else begin
          cmd.tab_wr      = 1'b1;
          cmd.tab_sel     = rrts_pkg::TS_IDLE;
          cmd.wr_sel      = rrts_pkg::WS_STATUS;
          cmd.wr_status   = rrts_pkg::ST_RUNNING;
          cmd.cur_to_idle = 1'b1;
        end
        state_next = rrts_pkg::S_OUT_RD;
      end
      rrts_pkg::S_POP: begin
        cmd.pop     = 1'b1;
        cmd.tab_rd  = 1'b1;
        cmd.tab_sel = rrts_pkg::TS_RING;
        state_next  = rrts_pkg::S_RUN;
      end
      rrts_pkg::S_RUN: begin
        cmd.tab_wr      = 1'b1;
        cmd.tab_sel     = rrts_pkg::TS_NEXT;
        cmd.wr_sel      = rrts_pkg::WS_STATUS;
        cmd.wr_status   = rrts_pkg::ST_RUNNING;
        cmd.cur_to_next = 1'b1;
        state_next      = rrts_pkg::S_OUT_RD;
      end
      rrts_pkg::S_OUT_RD: begin
        cmd.tab_rd  = 1'b1;
        cmd.tab_sel = rrts_pkg::TS_CUR;
        state_next  = rrts_pkg::S_OUT;
      end
      rrts_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = rrts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rrts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rrts_dp.sv */
module rrts_dp #(
  parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::sched_in_t           evt,
  input  logic                          cfg_valid,
  input  logic [rrts_pkg::SLOT_W-1:0]   cfg_data,
  output rrts_pkg::sched_out_t          res,
  output logic                          res_valid,
  input  logic                          res_stall,
  input  rrts_pkg::dp_cmd_t             cmd,
  output rrts_pkg::dp_sts_t             sts
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = IW + 1;
  localparam int SW = IW + 2;

  localparam logic [IW-1:0] LAST_SLOT  = IW'(TASK_SLOTS - 1);
  localparam logic [CW-1:0] RING_DEPTH = CW'(TASK_SLOTS);
  localparam logic [SW-1:0] WRAP       = SW'(TASK_SLOTS);

  rrts_pkg::sched_in_t        item;
  logic [rrts_pkg::SLOT_W-1:0] idle_task;
  logic [IW-1:0]              cur;
  logic [IW-1:0]              next_slot;
  logic [IW-1:0]              head;
  logic [CW-1:0]              count;
  logic [rrts_pkg::PID_W-1:0] pid;
  logic [rrts_pkg::PID_W-1:0] pid_out;
  rrts_pkg::err_t             err;
  logic                       switched;
  logic [TASK_SLOTS-1:0]      tab_valid;
  logic                       rd_hit;
  logic                       rd_zero;

  logic [IW-1:0]              req_idx;
  logic [IW-1:0]              idle_idx;
  logic [IW-1:0]              tab_addr;
  logic [rrts_pkg::ENTRY_W-1:0] tab_q;
  rrts_pkg::slot_entry_t      rd_ent;
  rrts_pkg::slot_entry_t      wr_ent;
  rrts_pkg::status_t          st_new;
  logic [IW-1:0]              ring_q;
  logic [IW-1:0]              ring_waddr;
  logic [IW-1:0]              ring_wdata;
  logic                       ring_we;
  logic                       ring_full;
  logic [SW-1:0]              tail_sum;
  logic [IW-1:0]              tail;
  logic [IW-1:0]              head_dec;
  logic [IW-1:0]              head_inc;

  assign req_idx  = IW'(item.task_req);
  assign idle_idx = IW'(idle_task);

  always_comb begin
    case (cmd.tab_sel)
      rrts_pkg::TS_CUR:  tab_addr = cur;
      rrts_pkg::TS_REQ:  tab_addr = req_idx;
      rrts_pkg::TS_IDLE: tab_addr = idle_idx;
      rrts_pkg::TS_NEXT: tab_addr = next_slot;
      default:           tab_addr = ring_q;
    endcase
  end

  // entries never written read as their reset value
  assign rd_ent = rd_hit ? rrts_pkg::slot_entry_t'(tab_q) :
                  (rd_zero ? rrts_pkg::ENTRY_MAIN : rrts_pkg::ENTRY_FREE);

  always_comb begin
    if (cmd.wr_use_kind) begin
      case (item.wait_kind)
        rrts_pkg::KIND_WAITING: st_new = rrts_pkg::ST_WAITING;
        rrts_pkg::KIND_HANGING: st_new = rrts_pkg::ST_HANGING;
        default:                st_new = rrts_pkg::ST_BLOCKED;
      endcase
    end else begin
      st_new = cmd.wr_status;
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      rrts_pkg::WS_CREATE: wr_ent = '{status: rrts_pkg::ST_READY,
                                      prio: item.priority_req, ticks: item.priority_req};
      rrts_pkg::WS_RELOAD: wr_ent = '{status: rrts_pkg::ST_READY,
                                      prio: rd_ent.prio, ticks: rd_ent.prio};
      default:             wr_ent = '{status: st_new, prio: rd_ent.prio, ticks: rd_ent.ticks};
    endcase
  end

  rrts_ram #(
    .WIDTH(rrts_pkg::ENTRY_W),
    .DEPTH(TASK_SLOTS)
  ) u_tab (
    .clk  (clk),
    .we   (cmd.tab_wr),
    .waddr(tab_addr),
    .wdata(wr_ent),
    .re   (cmd.tab_rd),
    .raddr(tab_addr),
    .rdata(tab_q)
  );

  // ring index arithmetic, modulo the slot count
  assign tail_sum   = SW'(head) + SW'(count);
  assign tail       = (tail_sum >= WRAP) ? IW'(tail_sum - WRAP) : IW'(tail_sum);
  assign head_dec   = (head == '0) ? LAST_SLOT : head - 1'b1;
  assign head_inc   = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign ring_full  = (count == RING_DEPTH);
  assign ring_we    = (cmd.push_back || cmd.push_front) && !ring_full;
  assign ring_waddr = cmd.push_front ? head_dec : tail;
  assign ring_wdata = (cmd.push_front || cmd.push_back_req) ? req_idx : cur;

  rrts_ram #(
    .WIDTH(IW),
    .DEPTH(TASK_SLOTS)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_waddr),
    .wdata(ring_wdata),
    .re   (cmd.ring_rd),
    .raddr(head),
    .rdata(ring_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_task <= rrts_pkg::IDLE_RESET;
      cur       <= '0;
      head      <= '0;
      count     <= '0;
      pid       <= '0;
      tab_valid <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        idle_task <= cfg_data;
      end
      if (cmd.tab_wr) begin
        tab_valid[tab_addr] <= 1'b1;
      end
      if (cmd.cur_to_idle) begin
        cur <= idle_idx;
      end else if (cmd.cur_to_next) begin
        cur <= next_slot;
      end
      if (cmd.push_front && !ring_full) begin
        head  <= head_dec;
        count <= count + 1'b1;
      end else if (cmd.push_back && !ring_full) begin
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end
      if (cmd.pid_inc) begin
        pid <= pid + 1'b1;
      end
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item     <= evt;
      err      <= rrts_pkg::ERR_NONE;
      switched <= 1'b0;
      pid_out  <= '0;
    end
    if (cmd.set_err) begin
      err <= cmd.err_code;
    end
    if (cmd.set_switched) begin
      switched <= 1'b1;
    end
    if (cmd.pid_inc) begin
      pid_out <= pid + 1'b1;
    end
    if (cmd.pop) begin
      next_slot <= ring_q;
    end
    if (cmd.tab_rd) begin
      rd_hit  <= tab_valid[tab_addr];
      rd_zero <= (tab_addr == '0);
    end
    if (cmd.load_out) begin
      res.running_task <= rrts_pkg::SLOT_W'(cur);
      res.slice_ticks  <= rd_ent.ticks;
      res.switched     <= switched;
      res.new_pid      <= pid_out;
      res.error        <= err;
    end
  end

  assign sts.mode       = item.mode;
  assign sts.req_ok     = (32'(item.task_req) < 32'(TASK_SLOTS));
  assign sts.idle_ok    = (32'(idle_task) < 32'(TASK_SLOTS));
  assign sts.rd_status  = rd_ent.status;
  assign sts.ring_empty = (count == '0);
  assign sts.out_free   = !res_valid || !res_stall;

endmodule

/* rtl/round_robin_task_scheduler.sv */
// Round-robin ready-queue task scheduler.
// Event channel (evt_valid / evt_stall / evt): one word per scheduler event
//   (create, reschedule, block, unblock, yield). A word is taken when
//   evt_valid is high and evt_stall is low; evt_stall stays high while an
//   event is being worked.
// Result channel (res_valid / res_stall / res): exactly one word per event,
//   held in an output register until res_stall is low.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes the idle-task
//   slot; always ready. Write it only while no event is in flight.
// Sequence: create and malformed events take the short path through the
//   sequencer, unblock the long one. The path is set by the shared read and
//   write address of the slot table: every read-modify-write of a slot entry
//   reads the entry first and writes it back afterwards, and each pass
//   touches up to three entries plus the ring.
// Receiver stall: a finished word waits in the output register; the next
//   event is still accepted and works up to its last step, where it waits.
// Reset (rst, synchronous): slot 0 running with 31 ticks, other slots free,
//   empty ready ring, pid counter 0, idle slot 1. No clearing pass is needed.
module round_robin_task_scheduler #(
  parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // event channel
  input  logic                        evt_valid,
  output logic                        evt_stall,
  input  rrts_pkg::sched_in_t         evt,
  // result channel
  output logic                        res_valid,
  input  logic                        res_stall,
  output rrts_pkg::sched_out_t        res,
  // idle-task register write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rrts_pkg::SLOT_W-1:0] cfg_data
);

  rrts_pkg::dp_cmd_t cmd;
  rrts_pkg::dp_sts_t sts;
  logic              cfg_we;

  // register write never back-pressures
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: steps each event through its slot-table and ring accesses
  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot table, ready ring, running slot, pid counter and result register
  rrts_dp #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .cfg_valid(cfg_we),
    .cfg_data (cfg_data),
    .res      (res),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
